>>> rtl/core/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared constants and types of the thermistor temperature stability block.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  // sensor and divider
  localparam int unsigned ADC_LEVELS          = 4096;
  localparam int unsigned BETA_KELVIN         = 3950;
  localparam int unsigned NOMINAL_OHMS        = 10000;
  localparam int unsigned SERIES_OHMS         = 10000;
  localparam int unsigned NOMINAL_CENTIKELVIN = 29815;

  // field widths
  localparam int CODE_W     = 12;
  localparam int TEMP_W     = 16;
  localparam int THR_W      = 16;
  localparam int NEED_W     = 8;
  localparam int PROG_W     = 7;
  localparam int EVENT_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDED    = 1'd1;

  // event codes of a result
  typedef enum logic [EVENT_W-1:0] {
    EV_QUIET       = 3'd0,
    EV_VARIATION   = 3'd1,
    EV_PROGRESS    = 3'd2,
    EV_STABLE_NEW  = 3'd3,
    EV_STABLE_SAME = 3'd4
  } event_e;

  // log2 datapath
  localparam longint unsigned OHMS_MAX =
    (SERIES_OHMS > NOMINAL_OHMS) ? longint'(SERIES_OHMS) : longint'(NOMINAL_OHMS);
  localparam longint unsigned PROD_MAX = OHMS_MAX * longint'(ADC_LEVELS - 1);
  localparam int PROD_W  = $clog2(PROD_MAX + 1);
  localparam int EXP_W   = $clog2(PROD_W);
  localparam int FRAC_W  = 24;
  localparam int FBIT_W  = $clog2(FRAC_W);
  localparam int MANT_W  = 31;
  localparam int LOG_W   = EXP_W + FRAC_W;

  // ln2 in q30
  localparam int LN2_W = 30;
  localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;

  // beta equation terms
  localparam longint unsigned NUMQ =
    longint'(BETA_KELVIN) * 64'd100 * (64'd1 << FRAC_W);
  localparam longint unsigned B_VAL = NUMQ / NOMINAL_CENTIKELVIN;
  localparam int B_W   = $clog2(B_VAL + 1);
  localparam int S_W   = ((LOG_W > B_W) ? LOG_W : B_W) + 2;
  localparam int NQ_W  = $clog2(NUMQ + 1);
  localparam int N_W   = ((NQ_W > S_W - 1) ? NQ_W : S_W - 1) + 1;
  localparam int DCNT_W = $clog2(N_W);

  // celsius conversion and saturation
  localparam int ZERO_C_CK = 27315;
  localparam int HOT_C     = 30000;
  localparam int SAT_Q     = HOT_C + ZERO_C_CK;
  localparam logic signed [TEMP_W-1:0] TEMP_HOT  = TEMP_W'(HOT_C);
  localparam logic signed [TEMP_W-1:0] TEMP_COLD = TEMP_W'(-ZERO_C_CK);

  // progress division
  localparam int CNT_MAX = 2**NEED_W - 1;
  localparam int PCT     = 100;
  localparam int PNUM_W  = $clog2(CNT_MAX * PCT + 1);
  localparam int PCNT_W  = $clog2(PNUM_W);

  // queue between conversion and tracking
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [NEED_W-1:0] needed;
  } cfg_t;

  typedef struct packed {
    logic                     push;
    logic signed [TEMP_W-1:0] temp;
  } q_wr_t;

  typedef struct packed {
    logic                     full;
    logic                     empty;
    logic signed [TEMP_W-1:0] temp;
  } q_rd_t;

endpackage

`default_nettype wire

>>> rtl/core/tts_log2.sv
// ----------------------------------------------------------------------------
// tts_log2
// Iterative base-2 logarithm in q24: bit-serial normalization, then one
// mantissa squaring per fraction bit.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_log2 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tts_pkg::PROD_W-1:0]  x_i,
  output logic                        busy_o,
  output logic [tts_pkg::LOG_W-1:0]   log_o
);
  import tts_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQR} state_e;

  state_e               state_q;
  logic [PROD_W-1:0]    x_q;
  logic [EXP_W-1:0]     exp_q;
  logic [FRAC_W-1:0]    frac_q;
  logic [MANT_W-1:0]    mant_q;
  logic [FBIT_W-1:0]    bit_q;

  logic [PROD_W+MANT_W-1:0] wide;
  logic [2*MANT_W-1:0]      sq;
  logic [MANT_W:0]          sq_top;

  assign wide   = {x_q, {MANT_W{1'b0}}};
  assign sq     = (2*MANT_W)'(mant_q) * (2*MANT_W)'(mant_q);
  assign sq_top = sq[2*MANT_W-1:MANT_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      x_q     <= '0;
      exp_q   <= '0;
      frac_q  <= '0;
      mant_q  <= '0;
      bit_q   <= '0;
    end else begin
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            x_q     <= x_i;
            exp_q   <= EXP_W'(PROD_W - 1);
            frac_q  <= '0;
            state_q <= L_NORM;
          end
        end
        L_NORM: begin
          if (x_q[PROD_W-1] || (exp_q == '0)) begin
            mant_q  <= wide[PROD_W+MANT_W-1 -: MANT_W];
            bit_q   <= FBIT_W'(FRAC_W - 1);
            state_q <= L_SQR;
          end else begin
            x_q   <= {x_q[PROD_W-2:0], 1'b0};
            exp_q <= exp_q - 1'b1;
          end
        end
        L_SQR: begin
          if (sq_top[MANT_W]) begin
            mant_q        <= sq_top[MANT_W:1];
            frac_q[bit_q] <= 1'b1;
          end else begin
            mant_q <= sq_top[MANT_W-1:0];
          end
          if (bit_q == '0) begin
            state_q <= L_IDLE;
          end else begin
            bit_q <= bit_q - 1'b1;
          end
        end
        default: begin
          state_q <= L_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != L_IDLE);
  assign log_o  = {exp_q, frac_q};

endmodule

`default_nettype wire

>>> rtl/core/tts_convert.sv
// ----------------------------------------------------------------------------
// tts_convert
// Front end: accepts adc codes, sorts out the limit codes and runs the beta
// equation through two log2 units, one multiply and a restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_convert (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tts_pkg::CODE_W-1:0]  adc_code_i,
  output tts_pkg::q_wr_t              wr_o,
  input  tts_pkg::q_rd_t              rd_i
);
  import tts_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE, C_LOG, C_MUL, C_SUM, C_CHK, C_DIV, C_SAT, C_PUSH
  } state_e;

  state_e                   state_q;
  logic [LOG_W-1:0]         mag_q;
  logic                     neg_q;
  logic [LOG_W-1:0]         lnmag_q;
  logic signed [S_W-1:0]    s_q;
  logic [N_W-1:0]           dvd_q;
  logic [S_W-2:0]           rem_q;
  logic [S_W-2:0]           dvs_q;
  logic [DCNT_W-1:0]        cnt_q;
  logic signed [TEMP_W-1:0] temp_q;

  logic                     limit_code;
  logic                     log_start;
  logic [PROD_W-1:0]        num;
  logic [PROD_W-1:0]        den;
  logic                     busy_num;
  logic                     busy_den;
  logic [LOG_W-1:0]         log_num;
  logic [LOG_W-1:0]         log_den;
  logic signed [LOG_W:0]    diff;
  logic signed [LOG_W:0]    diff_neg;
  logic [LOG_W+LN2_W-1:0]   prod;
  logic signed [S_W-1:0]    ln_ext;
  logic signed [S_W-1:0]    s_sum;
  logic [S_W-1:0]           rem_sh;
  logic [S_W-1:0]           rem_sub;
  logic                     rem_ge;
  logic signed [TEMP_W:0]   celsius;

  assign limit_code = (adc_code_i == '0) || (32'(adc_code_i) >= ADC_LEVELS);
  assign log_start  = (state_q == C_IDLE) && in_valid_i && !limit_code;
  assign num = PROD_W'(64'(SERIES_OHMS) * 64'(adc_code_i));
  assign den = PROD_W'(64'(NOMINAL_OHMS) * (64'(ADC_LEVELS) - 64'(adc_code_i)));

  tts_log2 u_log_num (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (num),
    .busy_o  (busy_num),
    .log_o   (log_num)
  );

  tts_log2 u_log_den (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (den),
    .busy_o  (busy_den),
    .log_o   (log_den)
  );

  assign diff     = $signed({1'b0, log_num}) - $signed({1'b0, log_den});
  assign diff_neg = -diff;
  assign prod     = (LOG_W+LN2_W)'(mag_q) * (LOG_W+LN2_W)'(LN2_Q30);
  assign ln_ext   = $signed({{(S_W-LOG_W){1'b0}}, lnmag_q});
  assign s_sum    = (neg_q ? -ln_ext : ln_ext) + $signed(S_W'(B_VAL));
  assign rem_sh   = {rem_q, dvd_q[N_W-1]};
  assign rem_sub  = rem_sh - {1'b0, dvs_q};
  assign rem_ge   = (rem_sh >= {1'b0, dvs_q});
  assign celsius  = $signed({1'b0, dvd_q[TEMP_W-1:0]}) - $signed((TEMP_W+1)'(ZERO_C_CK));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      lnmag_q <= '0;
      s_q     <= '0;
      dvd_q   <= '0;
      rem_q   <= '0;
      dvs_q   <= '0;
      cnt_q   <= '0;
      temp_q  <= '0;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (in_valid_i) begin
            if (limit_code) begin
              temp_q  <= TEMP_COLD;
              state_q <= C_PUSH;
            end else begin
              state_q <= C_LOG;
            end
          end
        end
        C_LOG: begin
          if (!busy_num && !busy_den) begin
            neg_q   <= diff[LOG_W];
            mag_q   <= diff[LOG_W] ? diff_neg[LOG_W-1:0] : diff[LOG_W-1:0];
            state_q <= C_MUL;
          end
        end
        C_MUL: begin
          lnmag_q <= prod[LOG_W+LN2_W-1:LN2_W];
          state_q <= C_SUM;
        end
        C_SUM: begin
          s_q     <= s_sum;
          state_q <= C_CHK;
        end
        C_CHK: begin
          if (s_q[S_W-1] || (s_q == '0)) begin
            temp_q  <= TEMP_HOT;
            state_q <= C_PUSH;
          end else begin
            dvd_q   <= N_W'(NUMQ) + N_W'(s_q[S_W-2:1]);
            dvs_q   <= s_q[S_W-2:0];
            rem_q   <= '0;
            cnt_q   <= DCNT_W'(N_W - 1);
            state_q <= C_DIV;
          end
        end
        C_DIV: begin
          rem_q <= rem_ge ? rem_sub[S_W-2:0] : rem_sh[S_W-2:0];
          dvd_q <= {dvd_q[N_W-2:0], rem_ge};
          if (cnt_q == '0) begin
            state_q <= C_SAT;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        C_SAT: begin
          if (dvd_q > N_W'(SAT_Q)) begin
            temp_q <= TEMP_HOT;
          end else begin
            temp_q <= celsius[TEMP_W-1:0];
          end
          state_q <= C_PUSH;
        end
        C_PUSH: begin
          if (!rd_i.full) begin
            state_q <= C_IDLE;
          end
        end
        default: begin
          state_q <= C_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o = (state_q != C_IDLE);
  assign wr_o.push  = (state_q == C_PUSH) && !rd_i.full;
  assign wr_o.temp  = temp_q;

endmodule

`default_nettype wire

>>> rtl/core/tts_queue.sv
// ----------------------------------------------------------------------------
// tts_queue
// Short fifo of converted temperatures between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tts_pkg::q_wr_t  wr_i,
  input  logic            pop_i,
  output tts_pkg::q_rd_t  rd_o
);
  import tts_pkg::*;

  logic signed [TEMP_W-1:0] mem_q [QDEPTH];
  logic [QPTR_W-1:0]        wr_ptr_q;
  logic [QPTR_W-1:0]        rd_ptr_q;
  logic [QCNT_W-1:0]        cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wr_ptr_q] <= wr_i.temp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i.push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i.push && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !wr_i.push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign rd_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign rd_o.empty = (cnt_q == '0);
  assign rd_o.temp  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> rtl/core/tts_track.sv
// ----------------------------------------------------------------------------
// tts_track
// Back end: stability tracking of the converted readings, progress
// division and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_track (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tts_pkg::cfg_t                      cfg_i,
  input  tts_pkg::q_rd_t                     rd_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [tts_pkg::TEMP_W-1:0]  temperature_now_o,
  output logic signed [tts_pkg::TEMP_W-1:0]  stable_value_o,
  output logic                               stable_flag_o,
  output logic                               variation_flag_o,
  output logic [tts_pkg::PROG_W-1:0]         progress_percent_o,
  output logic [tts_pkg::EVENT_W-1:0]        event_code_o
);
  import tts_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_DIV, T_FIN, T_OUT} state_e;

  function automatic logic [TEMP_W:0] abs_diff(input logic signed [TEMP_W-1:0] a,
                                               input logic signed [TEMP_W-1:0] b);
    logic signed [TEMP_W:0] d;
    logic signed [TEMP_W:0] dn;
    d  = $signed({a[TEMP_W-1], a}) - $signed({b[TEMP_W-1], b});
    dn = -d;
    return d[TEMP_W] ? dn : d;
  endfunction

  state_e                   state_q;
  event_e                   event_q;
  logic signed [TEMP_W-1:0] cur_q;
  logic signed [TEMP_W-1:0] prev_q;
  logic signed [TEMP_W-1:0] stable_q;
  logic [NEED_W-1:0]        count_q;
  logic                     watch_q;
  logic                     settled_q;
  logic [PNUM_W-1:0]        pnum_q;
  logic [NEED_W-1:0]        prem_q;
  logic [PCNT_W-1:0]        pcnt_q;
  logic [PROG_W-1:0]        prog_q;

  logic [NEED_W-1:0]        need_eff;
  logic [NEED_W-1:0]        count_inc;
  logic                     big_step;
  logic                     big_move;
  logic [NEED_W:0]          prem_sh;
  logic [NEED_W:0]          prem_sub;
  logic                     prem_ge;

  assign need_eff  = (cfg_i.needed == '0) ? NEED_W'(1) : cfg_i.needed;
  assign count_inc = (count_q == NEED_W'(CNT_MAX)) ? count_q : count_q + 1'b1;
  assign big_step  = abs_diff(rd_i.temp, prev_q) > {1'b0, cfg_i.threshold};
  assign big_move  = abs_diff(cur_q, stable_q) > {1'b0, cfg_i.threshold};
  assign prem_sh   = {prem_q, pnum_q[PNUM_W-1]};
  assign prem_sub  = prem_sh - {1'b0, need_eff};
  assign prem_ge   = (prem_sh >= {1'b0, need_eff});
  assign pop_o     = (state_q == T_IDLE) && !rd_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      event_q   <= EV_QUIET;
      cur_q     <= '0;
      prev_q    <= '0;
      stable_q  <= '0;
      count_q   <= '0;
      watch_q   <= 1'b0;
      settled_q <= 1'b0;
      pnum_q    <= '0;
      prem_q    <= '0;
      pcnt_q    <= '0;
      prog_q    <= '0;
    end else begin
      case (state_q)
        T_IDLE: begin
          if (!rd_i.empty) begin
            cur_q  <= rd_i.temp;
            prev_q <= rd_i.temp;
            if (big_step) begin
              watch_q   <= 1'b1;
              settled_q <= 1'b0;
              count_q   <= '0;
              prog_q    <= '0;
              event_q   <= EV_VARIATION;
              state_q   <= T_OUT;
            end else if (watch_q) begin
              count_q <= count_inc;
              pnum_q  <= PNUM_W'(PNUM_W'(count_inc) * PNUM_W'(PCT));
              prem_q  <= '0;
              pcnt_q  <= PCNT_W'(PNUM_W - 1);
              state_q <= T_DIV;
            end else begin
              prog_q  <= '0;
              event_q <= EV_QUIET;
              state_q <= T_OUT;
            end
          end
        end
        T_DIV: begin
          prem_q <= prem_ge ? prem_sub[NEED_W-1:0] : prem_sh[NEED_W-1:0];
          pnum_q <= {pnum_q[PNUM_W-2:0], prem_ge};
          if (pcnt_q == '0) begin
            state_q <= T_FIN;
          end else begin
            pcnt_q <= pcnt_q - 1'b1;
          end
        end
        T_FIN: begin
          prog_q <= (pnum_q > PNUM_W'(PCT)) ? PROG_W'(PCT) : pnum_q[PROG_W-1:0];
          if (count_q >= need_eff) begin
            settled_q <= 1'b1;
            watch_q   <= 1'b0;
            if (big_move) begin
              stable_q <= cur_q;
              event_q  <= EV_STABLE_NEW;
            end else begin
              event_q  <= EV_STABLE_SAME;
            end
          end else begin
            event_q <= EV_PROGRESS;
          end
          state_q <= T_OUT;
        end
        T_OUT: begin
          if (!out_stall_i) begin
            state_q <= T_IDLE;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o        = (state_q == T_OUT);
  assign temperature_now_o  = cur_q;
  assign stable_value_o     = stable_q;
  assign stable_flag_o      = settled_q;
  assign variation_flag_o   = watch_q;
  assign progress_percent_o = prog_q;
  assign event_code_o       = event_q;

endmodule

`default_nettype wire

>>> rtl/core/thermistor_temperature_stability.sv
// ----------------------------------------------------------------------------
// thermistor_temperature_stability
// NTC thermistor code to temperature conversion with stability tracking.
// ----------------------------------------------------------------------------
// Each item is one 12-bit adc code; each gives one result with the
// temperature in hundredths of a degree Celsius (beta equation, saturated to
// +300.00 C), the stable value, both flags, settling progress and an event
// code. A zero code or an open sensor reads as -273.15 C. A normal code runs
// in the front end through the bit-serial log2 normalization, 24 mantissa
// squarings and a 44-step restoring divider; limit codes skip them. The back
// end runs a bit-serial progress division on readings taken while settling,
// and a two-entry queue lets the front end take the next code while a
// result waits on the output. The user must write registers only while the
// block is idle; the block does not enforce this. Index 0 is the steady
// threshold, index 1 the count of steady readings needed.
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_temperature_stability (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tts_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [tts_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [tts_pkg::CODE_W-1:0]            adc_code_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [tts_pkg::TEMP_W-1:0]     temperature_now_o,
  output logic signed [tts_pkg::TEMP_W-1:0]     stable_value_o,
  output logic                                  stable_flag_o,
  output logic                                  variation_flag_o,
  output logic [tts_pkg::PROG_W-1:0]            progress_percent_o,
  output logic [tts_pkg::EVENT_W-1:0]           event_code_o
);
  import tts_pkg::*;

  cfg_t  cfg_q;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THR_W'(50);
      cfg_q.needed    <= NEED_W'(10);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: cfg_q.threshold <= cfg_wdata_i[THR_W-1:0];
        CFG_NEEDED:    cfg_q.needed    <= cfg_wdata_i[NEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tts_convert u_convert (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .adc_code_i (adc_code_i),
    .wr_o       (q_wr),
    .rd_i       (q_rd)
  );

  tts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .pop_i  (q_pop),
    .rd_o   (q_rd)
  );

  tts_track u_track (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .rd_i               (q_rd),
    .pop_o              (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .temperature_now_o  (temperature_now_o),
    .stable_value_o     (stable_value_o),
    .stable_flag_o      (stable_flag_o),
    .variation_flag_o   (variation_flag_o),
    .progress_percent_o (progress_percent_o),
    .event_code_o       (event_code_o)
  );

endmodule

`default_nettype wire

>>> test/tts_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tts_checker
// Predicts and checks the results of the thermistor stability block.
// ----------------------------------------------------------------------------
// Watches the register port and both channels. Every accepted adc code is
// converted to centidegrees with a fixed-point beta equation and run through
// a copy of the stability tracking; the expected result is queued and
// compared field by field with the next accepted result.
// ----------------------------------------------------------------------------

module tts_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tts_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [tts_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic [tts_pkg::CODE_W-1:0]            adc_code_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic signed [tts_pkg::TEMP_W-1:0]     temperature_now_i,
  input  logic signed [tts_pkg::TEMP_W-1:0]     stable_value_i,
  input  logic                                  stable_flag_i,
  input  logic                                  variation_flag_i,
  input  logic [tts_pkg::PROG_W-1:0]            progress_percent_i,
  input  logic [tts_pkg::EVENT_W-1:0]           event_code_i,
  output int unsigned                           pending_o,
  output int unsigned                           mismatches_o,
  output int unsigned                           compared_o,
  output int unsigned                           variations_o,
  output int unsigned                           stable_events_o
);

  import tts_pkg::*;

  localparam int Q_FRAC     = 24;
  localparam int PRINT_MAX  = 40;
  localparam int COUNT_SAT  = 255;
  localparam int PCT_FULL   = 100;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_now;
    logic signed [TEMP_W-1:0] stable;
    logic                     stable_flag;
    logic                     variation_flag;
    logic [PROG_W-1:0]        progress;
    logic [EVENT_W-1:0]       event_code;
  } reading_t;

  reading_t          expected_readings[$];
  logic [THR_W-1:0]  threshold_cfg;
  logic [NEED_W-1:0] needed_cfg;
  int                last_temp;
  int                settled_temp;
  int                steady_cnt;
  logic              watching;
  logic              settled;

  function automatic longint log2_fixed(longint unsigned x);
    int              e;
    longint unsigned m;
    longint          r;
    e = 63;
    while (e > 0 && x[e] == 1'b0) e--;
    if (e >= 30) m = x >> (e - 30);
    else m = x << (30 - e);
    r = longint'(e) << Q_FRAC;
    for (int i = Q_FRAC - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r = r + (longint'(1) << i);
      end
    end
    return r;
  endfunction

  function automatic logic signed [TEMP_W-1:0] code_to_centicelsius(logic [CODE_W-1:0] code);
    longint          diff;
    longint unsigned mag;
    longint          ln_term;
    longint          numq;
    longint          beta_term;
    longint          s;
    longint          ck;
    longint          c;
    if (code == '0 || 64'(code) >= 64'(ADC_LEVELS)) return TEMP_COLD;
    diff = log2_fixed(64'(SERIES_OHMS) * 64'(code))
         - log2_fixed(64'(NOMINAL_OHMS) * (64'(ADC_LEVELS) - 64'(code)));
    mag = (diff < 0) ? longint'(-diff) : diff;
    mag = (mag * 64'(LN2_Q30)) >> 30;
    ln_term = (diff < 0) ? -longint'(mag) : longint'(mag);
    numq = longint'(BETA_KELVIN) * 100 * (longint'(1) << Q_FRAC);
    beta_term = numq / longint'(NOMINAL_CENTIKELVIN);
    s = ln_term + beta_term;
    if (s <= 0) return TEMP_HOT;
    ck = (numq + s / 2) / s;
    c = ck - ZERO_C_CK;
    if (c > HOT_C) c = HOT_C;
    if (c < -HOT_C) c = -HOT_C;
    return TEMP_W'(c);
  endfunction

  function automatic reading_t track_reading(logic [CODE_W-1:0] code);
    reading_t       res;
    int             cur;
    int             step;
    int             dv;
    int             need;
    int             pct;
    event_e         ev;
    cur  = int'(code_to_centicelsius(code));
    step = cur - last_temp;
    if (step < 0) step = -step;
    need = (needed_cfg != '0) ? int'(needed_cfg) : 1;
    pct  = 0;
    ev   = EV_QUIET;
    if (step > int'(threshold_cfg)) begin
      watching   = 1'b1;
      settled    = 1'b0;
      steady_cnt = 0;
      ev         = EV_VARIATION;
    end else if (watching) begin
      if (steady_cnt < COUNT_SAT) steady_cnt++;
      pct = steady_cnt * PCT_FULL / need;
      if (pct > PCT_FULL) pct = PCT_FULL;
      ev = EV_PROGRESS;
      if (steady_cnt >= need) begin
        dv = cur - settled_temp;
        if (dv < 0) dv = -dv;
        settled  = 1'b1;
        watching = 1'b0;
        if (dv > int'(threshold_cfg)) begin
          settled_temp = cur;
          ev = EV_STABLE_NEW;
        end else begin
          ev = EV_STABLE_SAME;
        end
      end
    end
    last_temp = cur;
    res.temp_now       = TEMP_W'(cur);
    res.stable         = TEMP_W'(settled_temp);
    res.stable_flag    = settled;
    res.variation_flag = watching;
    res.progress       = PROG_W'(pct);
    res.event_code     = ev;
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    if (mismatches_o < PRINT_MAX)
      $display("%0t ERROR result %0d: %s is %0d, expected %0d",
               $realtime, compared_o, field, got, want);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      expected_readings.delete();
      threshold_cfg   = THR_W'(50);
      needed_cfg      = NEED_W'(10);
      last_temp       = 0;
      settled_temp    = 0;
      steady_cnt      = 0;
      watching        = 1'b0;
      settled         = 1'b0;
      pending_o       = 0;
      mismatches_o    = 0;
      compared_o      = 0;
      variations_o    = 0;
      stable_events_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result without item, event", int'(event_code_i), -1);
        end else begin
          want = expected_readings.pop_front();
          if (temperature_now_i !== want.temp_now)
            report_mismatch("temperature_now", int'(temperature_now_i), int'(want.temp_now));
          if (stable_value_i !== want.stable)
            report_mismatch("stable_value", int'(stable_value_i), int'(want.stable));
          if (stable_flag_i !== want.stable_flag)
            report_mismatch("stable_flag", int'(stable_flag_i), int'(want.stable_flag));
          if (variation_flag_i !== want.variation_flag)
            report_mismatch("variation_flag", int'(variation_flag_i),
                            int'(want.variation_flag));
          if (progress_percent_i !== want.progress)
            report_mismatch("progress_percent", int'(progress_percent_i), int'(want.progress));
          if (event_code_i !== want.event_code)
            report_mismatch("event_code", int'(event_code_i), int'(want.event_code));
          if (want.event_code == EV_VARIATION) variations_o++;
          if (want.event_code == EV_STABLE_NEW || want.event_code == EV_STABLE_SAME)
            stable_events_o++;
        end
        compared_o++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD: threshold_cfg = cfg_wdata_i[THR_W-1:0];
          CFG_NEEDED:    needed_cfg = cfg_wdata_i[NEED_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_readings.push_back(track_reading(adc_code_i));
      pending_o = expected_readings.size();
    end
  end

endmodule

>>> test/tb_thermistor_temperature_stability.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_thermistor_temperature_stability
// Stimulus and verdict for the thermistor temperature stability block.
// ----------------------------------------------------------------------------
// A directed run covers the code extremes, hot saturation, the limit codes,
// a zero needed count and a needed count lowered while settling. Then random
// settling episodes (a jump followed by a run of nearly equal codes, mixed
// with noise and cut-short runs) are played under several register settings.
// Both channels idle at random; the receiver holds off for long stretches and
// the sender pauses until the block is drained. A checker module predicts
// and compares every result.
// ----------------------------------------------------------------------------

module tb_thermistor_temperature_stability;

  import tts_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_HOLD      = 1000;
  localparam int TAIL_CYCLES    = 300;
  localparam int NUM_SETTINGS   = 7;
  localparam int CODE_MAX       = 4095;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CODE_W-1:0]        adc_code = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [TEMP_W-1:0] temp_now;
  logic signed [TEMP_W-1:0] stable_val;
  logic                     stable_flag;
  logic                     variation_flag;
  logic [PROG_W-1:0]        progress;
  logic [EVENT_W-1:0]       event_code;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned compared;
  int unsigned variations;
  int unsigned stable_events;

  int idle_cycles = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int codes_sent = 0;
  bit steady_sender = 1'b0;

  thermistor_temperature_stability i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .adc_code_i         (adc_code),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .temperature_now_o  (temp_now),
    .stable_value_o     (stable_val),
    .stable_flag_o      (stable_flag),
    .variation_flag_o   (variation_flag),
    .progress_percent_o (progress),
    .event_code_o       (event_code)
  );

  tts_checker i_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .adc_code_i         (adc_code),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .temperature_now_i  (temp_now),
    .stable_value_i     (stable_val),
    .stable_flag_i      (stable_flag),
    .variation_flag_i   (variation_flag),
    .progress_percent_i (progress),
    .event_code_i       (event_code),
    .pending_o          (pending),
    .mismatches_o       (mismatches),
    .compared_o         (compared),
    .variations_o       (variations),
    .stable_events_o    (stable_events)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t timeout: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int code_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_sender || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, quiet stretches and requested long hold-offs
  initial begin
    int hold_len;
    int r;
    bit stall_val;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_served != hold_asked) begin
        hold_served++;
        stall_val = 1'b1;
        hold_len  = LONG_HOLD;
      end else if (r < 15) begin
        stall_val = 1'b1;
        hold_len  = $urandom_range(1, 3);
      end else if (r < 19) begin
        stall_val = 1'b1;
        hold_len  = $urandom_range(10, 40);
      end else if (r < 26) begin
        stall_val = 1'b0;
        hold_len  = $urandom_range(50, 150);
      end else begin
        stall_val = 1'b0;
        hold_len  = $urandom_range(1, 6);
      end
      out_stall <= stall_val;
      repeat (hold_len) @(posedge clk);
    end
  end

  task automatic send_code(logic [CODE_W-1:0] code);
    int gap;
    gap = code_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_code <= code;
    do @(posedge clk); while (in_stall);
    codes_sent++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_settings(logic [THR_W-1:0] thr, logic [NEED_W-1:0] need);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_idx   <= CFG_NEEDED;
    cfg_wdata <= {NEED_W'($urandom_range(0, 255)), need};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // settling episodes: a jump, then a run of near-equal codes, with noise
  task automatic run_settle_episodes(int count, int need);
    int base;
    int run_len;
    int code;
    int left;
    int r;
    left = count;
    while (left > 0) begin
      base = ($urandom_range(0, 9) < 8) ? $urandom_range(200, 3900) : $urandom_range(0, CODE_MAX);
      send_code(CODE_W'(base));
      left--;
      r = $urandom_range(0, 9);
      if (r < 7) run_len = need + $urandom_range(0, 3);
      else run_len = $urandom_range(0, need);
      if (run_len > left) run_len = left;
      for (int k = 0; k < run_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 50) code = base;
        else if (r < 90) code = base + $urandom_range(0, 4) - 2;
        else code = $urandom_range(0, CODE_MAX);
        if (code < 0) code = 0;
        if (code > CODE_MAX) code = CODE_MAX;
        send_code(CODE_W'(code));
        left--;
        if ($urandom_range(0, 99) < 2) wait_all_results();
      end
    end
  endtask

  initial begin
    logic [THR_W-1:0]  thr_list[NUM_SETTINGS];
    logic [NEED_W-1:0] need_list[NUM_SETTINGS];
    int                count_list[NUM_SETTINGS];
    thr_list   = '{16'd50, 16'd0, 16'd60000, 16'd200, 16'd25, 16'd1000, 16'hFFFF};
    need_list  = '{8'd10, 8'd1, 8'd3, 8'd255, 8'd0, 8'd5, 8'd1};
    count_list = '{200, 150, 100, 320, 150, 200, 60};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // limit codes, hot saturation and bit extremes under reset settings
    send_code(12'd0);
    send_code(12'hFFF);
    send_code(12'd1);
    send_code(12'd7);
    send_code(12'd8);
    send_code(12'hAAA);
    send_code(12'h555);
    repeat (6) send_code(12'd2048);
    // needed count lowered below the running count
    wait_all_results();
    write_settings(16'd50, 8'd2);
    send_code(12'd2048);
    send_code(12'd2048);
    send_code(12'd0);
    send_code(12'd2048);
    send_code(12'd2048);
    send_code(12'd2048);
    // needed count of zero
    wait_all_results();
    write_settings(16'd0, 8'd0);
    send_code(12'hFFF);
    send_code(12'hFFF);

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      wait_all_results();
      write_settings(thr_list[p], need_list[p]);
      steady_sender = (p == 2 || p == 6);
      if (p == 1 || p == 4) hold_asked++;
      run_settle_episodes(count_list[p], int'(need_list[p]));
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d codes over %0d register settings plus directed extremes,",
             codes_sent, NUM_SETTINGS);
    $display("with %0d results compared: %0d variations and %0d stable decisions.",
             compared, variations, stable_events);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
